FILE: src/hsfd_pkg.sv
// Shared types and constants for the HEVC sync frame detector.
`default_nettype none
package hsfd_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned NAL_TYPE_W   = 6;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = NAL_TYPE_W;
    localparam int unsigned PREFIX_BYTES = 4;
    localparam int unsigned PREFIX_W     = PREFIX_BYTES * BYTE_W;
    localparam int unsigned COUNT_W      = 3;

    localparam logic [BYTE_W-1:0]     NAL_TYPE_MASK = 8'h7E;
    localparam logic [NAL_TYPE_W-1:0] SYNC_LOW_RST  = 6'd17;
    localparam logic [NAL_TYPE_W-1:0] SYNC_HIGH_RST = 6'd23;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_LOW  = 2'd0,
        CFG_SYNC_HIGH = 2'd1
    } t_cfg_idx;

    typedef logic [BYTE_W-1:0]     t_byte;
    typedef logic [NAL_TYPE_W-1:0] t_nal_type;

endpackage
`default_nettype wire

FILE: src/hsfd_if.sv
// Valid/ready channel interfaces for packet bytes and per-packet results.
`default_nettype none
interface hsfd_byte_if;
    logic              valid;
    logic              ready;
    hsfd_pkg::t_byte   data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hsfd_result_if;
    logic valid;
    logic ready;
    logic is_sync;
    logic annexb_format;
    logic too_short;

    modport source (output valid, output is_sync, output annexb_format, output too_short,
                    input ready);
    modport sink   (input valid, input is_sync, input annexb_format, input too_short,
                    output ready);
endinterface
`default_nettype wire

FILE: src/hevc_sync_frame_detector.sv
// Registered result: valid in the cycle after the beat that carries the last packet byte.
// One byte per cycle unless a held result blocks the input; all tracker state updates in
// the cycle the beat is taken. The result register frees the input side: a new beat is
// taken while a result waits as long as the sink takes that result in the same cycle.
// Reset (synchronous, active low) clears both trackers, empties the result register
// and sets the sync type range back to 17..23.
`default_nettype none
module hevc_sync_frame_detector (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [hsfd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [hsfd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    hsfd_byte_if.sink                            i_byte,
    hsfd_result_if.source                        o_result
);

    // Configuration
    hsfd_pkg::t_nal_type r_sync_low;
    hsfd_pkg::t_nal_type r_sync_high;

    // Format detection
    logic [hsfd_pkg::COUNT_W-1:0]  r_count,  n_count;
    logic [hsfd_pkg::PREFIX_W-1:0] r_head,   n_head;

    // Annex B tracker
    logic [1:0] r_zero_run, n_zero_run;
    logic       r_ab_hdr,   n_ab_hdr;
    logic       r_ab_found, n_ab_found;

    // Length prefix tracker
    logic [hsfd_pkg::PREFIX_W-1:0] r_acc,      n_acc;
    logic [1:0]                    r_idx,      n_idx;
    logic [hsfd_pkg::PREFIX_W-2:0] r_payload,  n_payload;
    logic                          r_in_pfx,   n_in_pfx;
    logic                          r_first,    n_first;
    logic                          r_len_hdr,  n_len_hdr;
    logic                          r_len_stop, n_len_stop;
    logic                          r_len_found, n_len_found;

    // Result register
    logic r_out_valid;
    logic r_is_sync, r_annexb, r_too_short;
    logic n_is_sync, n_annexb, n_too_short;

    logic                          in_fire;
    logic                          byte_sync;
    hsfd_pkg::t_byte               b;
    hsfd_pkg::t_nal_type           nal_type;
    logic [hsfd_pkg::PREFIX_W-1:0] acc_shift;

    assign b         = i_byte.data_byte;
    assign i_byte.ready = !r_out_valid || o_result.ready;
    assign in_fire   = i_byte.valid && i_byte.ready;
    assign nal_type  = hsfd_pkg::t_nal_type'((b & hsfd_pkg::NAL_TYPE_MASK) >> 1);
    assign byte_sync = (nal_type >= r_sync_low) && (nal_type <= r_sync_high);
    assign acc_shift = {r_acc[hsfd_pkg::PREFIX_W-hsfd_pkg::BYTE_W-1:0], b};

    // Capture the head bytes and count them, saturating at the prefix size
    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        if (r_count < hsfd_pkg::COUNT_W'(hsfd_pkg::PREFIX_BYTES)) begin
            n_count = r_count + 1'b1;
            n_head  = {r_head[hsfd_pkg::PREFIX_W-hsfd_pkg::BYTE_W-1:0], b};
        end
    end

    // Annex B: flag the byte after each 00 00 01 as a header
    always_comb begin
        n_ab_found = r_ab_found || (r_ab_hdr && byte_sync);
        n_ab_hdr   = (b == hsfd_pkg::t_byte'(1)) && (r_zero_run == 2'd2);
        if (b == '0) begin
            n_zero_run = (r_zero_run == 2'd2) ? 2'd2 : r_zero_run + 2'd1;
        end else begin
            n_zero_run = 2'd0;
        end
    end

    // Length prefixed: walk prefixes and payloads, check the byte after each prefix
    always_comb begin
        n_acc       = r_acc;
        n_idx       = r_idx;
        n_payload   = r_payload;
        n_in_pfx    = r_in_pfx;
        n_first     = r_first;
        n_len_hdr   = r_len_hdr;
        n_len_stop  = r_len_stop;
        n_len_found = r_len_found;
        if (!r_len_stop) begin
            n_len_found = r_len_found || (r_len_hdr && byte_sync);
            n_len_hdr   = 1'b0;
            if (r_in_pfx) begin
                if (r_idx == 2'(hsfd_pkg::PREFIX_BYTES - 1)) begin
                    n_idx = 2'd0;
                    n_acc = '0;
                    if (acc_shift[hsfd_pkg::PREFIX_W-1] || (r_first && acc_shift == '0)) begin
                        n_len_stop = 1'b1;
                    end else begin
                        n_first   = 1'b0;
                        n_len_hdr = 1'b1;
                        if (acc_shift != '0) begin
                            n_payload = acc_shift[hsfd_pkg::PREFIX_W-2:0];
                            n_in_pfx  = 1'b0;
                        end
                    end
                end else begin
                    n_acc = acc_shift;
                    n_idx = r_idx + 2'd1;
                end
            end else begin
                if (r_payload <= (hsfd_pkg::PREFIX_W-1)'(1)) begin
                    n_payload = '0;
                    n_in_pfx  = 1'b1;
                end else begin
                    n_payload = r_payload - 1'b1;
                end
            end
        end
    end

    // Pick the answering tracker from the head bytes
    always_comb begin
        logic [hsfd_pkg::BYTE_W-1:0] b0, b1, b2, b3;
        b0 = n_head[31:24];
        b1 = n_head[23:16];
        b2 = n_head[15:8];
        b3 = n_head[7:0];
        n_too_short = n_count < hsfd_pkg::COUNT_W'(hsfd_pkg::PREFIX_BYTES);
        n_annexb    = !n_too_short && (b0 == '0) && (b1 == '0) &&
                      ((b2 == hsfd_pkg::t_byte'(1)) || ((b2 == '0) && (b3 == hsfd_pkg::t_byte'(1))));
        n_is_sync   = !n_too_short && (n_annexb ? n_ab_found : n_len_found);
    end

    // Configuration writes; drop indexes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_low  <= hsfd_pkg::SYNC_LOW_RST;
            r_sync_high <= hsfd_pkg::SYNC_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hsfd_pkg::CFG_SYNC_LOW:  r_sync_low  <= i_cfg_data;
                hsfd_pkg::CFG_SYNC_HIGH: r_sync_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance tracker state per beat; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_fire && i_byte.last_byte)) begin
            r_count     <= '0;
            r_head      <= '0;
            r_zero_run  <= '0;
            r_ab_hdr    <= 1'b0;
            r_ab_found  <= 1'b0;
            r_acc       <= '0;
            r_idx       <= '0;
            r_payload   <= '0;
            r_in_pfx    <= 1'b1;
            r_first     <= 1'b1;
            r_len_hdr   <= 1'b0;
            r_len_stop  <= 1'b0;
            r_len_found <= 1'b0;
        end else if (in_fire) begin
            r_count     <= n_count;
            r_head      <= n_head;
            r_zero_run  <= n_zero_run;
            r_ab_hdr    <= n_ab_hdr;
            r_ab_found  <= n_ab_found;
            r_acc       <= n_acc;
            r_idx       <= n_idx;
            r_payload   <= n_payload;
            r_in_pfx    <= n_in_pfx;
            r_first     <= n_first;
            r_len_hdr   <= n_len_hdr;
            r_len_stop  <= n_len_stop;
            r_len_found <= n_len_found;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && i_byte.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_byte.last_byte) begin
            r_is_sync   <= n_is_sync;
            r_annexb    <= n_annexb;
            r_too_short <= n_too_short;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.is_sync       = r_is_sync;
    assign o_result.annexb_format = r_annexb;
    assign o_result.too_short     = r_too_short;

    // A short packet never claims a format or a sync unit
    a_short_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_too_short) |-> (!r_is_sync && !r_annexb))
        else $error("short packet result carries sync or format flag");

    // The last byte always yields a result and restarts the trackers
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_byte.last_byte) |=> (r_out_valid && r_count == '0 && r_in_pfx))
        else $error("last byte did not produce a result or clear state");

    // Payload phase always has bytes left to skip
    a_payload_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_pfx |-> (r_payload != '0))
        else $error("payload phase with zero bytes remaining");

    // A stopped length parse never arms a header check
    a_stop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len_stop |-> !r_len_hdr)
        else $error("header check armed after length parse stopped");

    // No beat is taken while a result is stuck
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !i_byte.ready)
        else $error("beat taken while result register is blocked");

endmodule
`default_nettype wire

FILE: tb/hsfd_sync_checker.sv
// Scoreboard that predicts and checks the per-packet verdicts of the sync frame detector.
module hsfd_sync_checker
    import hsfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hsfd_byte_if                  i_byte,
    hsfd_result_if                i_result,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_byte START_ZERO = 8'h00;
    localparam t_byte START_ONE  = 8'h01;

    typedef struct packed {
        logic is_sync;
        logic annexb_format;
        logic too_short;
    } t_verdict;

    // Sync type range as the block holds it
    t_nal_type type_low;
    t_nal_type type_high;

    // Packet head and format decision
    logic [COUNT_W-1:0]  head_count;
    logic [PREFIX_W-1:0] head_word;

    // Start code tracker
    logic [1:0] zero_run;
    logic       sc_header_next;
    logic       sc_found;

    // Length prefix tracker
    logic [PREFIX_W-1:0] prefix_word;
    logic [1:0]          prefix_pos;
    logic [PREFIX_W-2:0] payload_left;
    logic                in_prefix;
    logic                first_prefix;
    logic                lp_header_next;
    logic                lp_stopped;
    logic                lp_found;

    t_verdict verdict_q[$];
    int       fails = 0;

    function automatic logic type_in_range(t_byte b);
        t_nal_type nal_type;
        nal_type = t_nal_type'((b & NAL_TYPE_MASK) >> 1);
        return (nal_type >= type_low) && (nal_type <= type_high);
    endfunction

    task automatic clear_packet_state();
        head_count     = '0;
        head_word      = '0;
        zero_run       = '0;
        sc_header_next = 1'b0;
        sc_found       = 1'b0;
        prefix_word    = '0;
        prefix_pos     = '0;
        payload_left   = '0;
        in_prefix      = 1'b1;
        first_prefix   = 1'b1;
        lp_header_next = 1'b0;
        lp_stopped     = 1'b0;
        lp_found       = 1'b0;
    endtask

    // Check the byte after each 00 00 01; a header byte may open the next start code
    task automatic track_start_codes(t_byte b);
        if (sc_header_next) begin
            if (type_in_range(b)) sc_found = 1'b1;
            sc_header_next = 1'b0;
        end
        if (b == START_ZERO) begin
            if (zero_run < 2'd2) zero_run++;
        end else begin
            if (b == START_ONE && zero_run == 2'd2) sc_header_next = 1'b1;
            zero_run = '0;
        end
    endtask

    // Walk big-endian length prefixes and check the byte after each one
    task automatic track_length_prefix(t_byte b);
        logic [PREFIX_W-1:0] len;
        if (lp_stopped) return;
        if (lp_header_next) begin
            if (type_in_range(b)) lp_found = 1'b1;
            lp_header_next = 1'b0;
        end
        if (in_prefix) begin
            prefix_word = {prefix_word[PREFIX_W-BYTE_W-1:0], b};
            if (prefix_pos == 2'(PREFIX_BYTES - 1)) begin
                len         = prefix_word;
                prefix_pos  = '0;
                prefix_word = '0;
                if (len[PREFIX_W-1] || (first_prefix && len == '0)) begin
                    lp_stopped = 1'b1;
                end else begin
                    first_prefix   = 1'b0;
                    lp_header_next = 1'b1;
                    // a zero length keeps parsing prefixes
                    if (len != '0) begin
                        payload_left = len[PREFIX_W-2:0];
                        in_prefix    = 1'b0;
                    end
                end
            end else begin
                prefix_pos++;
            end
        end else if (payload_left <= 1) begin
            payload_left = '0;
            in_prefix    = 1'b1;
        end else begin
            payload_left--;
        end
    endtask

    // Advance both trackers by one byte; the last byte yields the verdict
    task automatic predict_byte(t_byte b, logic last);
        t_verdict want;
        logic     annexb;
        if (head_count < PREFIX_BYTES) begin
            head_word = {head_word[PREFIX_W-BYTE_W-1:0], b};
            head_count++;
        end
        track_start_codes(b);
        track_length_prefix(b);
        if (!last) return;
        if (head_count < PREFIX_BYTES) begin
            want = '{is_sync: 1'b0, annexb_format: 1'b0, too_short: 1'b1};
        end else begin
            annexb = (head_word[31:8] == {START_ZERO, START_ZERO, START_ONE}) ||
                     (head_word == {START_ZERO, START_ZERO, START_ZERO, START_ONE});
            want = '{is_sync: annexb ? sc_found : lp_found, annexb_format: annexb,
                     too_short: 1'b0};
        end
        verdict_q.insert(verdict_q.size(), want);
        clear_packet_state();
    endtask

    // Watch register writes, result beats and byte beats at each edge
    always @(posedge i_clk) begin : monitor
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            type_low  = SYNC_LOW_RST;
            type_high = SYNC_HIGH_RST;
            clear_packet_state();
            verdict_q.delete();
        end else begin
            // a result beat belongs to an earlier last byte, so retire it first
            if (i_result.valid && i_result.ready) begin
                got = '{is_sync: i_result.is_sync, annexb_format: i_result.annexb_format,
                        too_short: i_result.too_short};
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result beat sync %b annexb %b short %b",
                             $time, got.is_sync, got.annexb_format, got.too_short);
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected sync/annexb/short %b%b%b, actual %b%b%b",
                                 $time, want.is_sync, want.annexb_format, want.too_short,
                                 got.is_sync, got.annexb_format, got.too_short);
                        fails++;
                    end
                end
            end
            if (i_byte.valid && i_byte.ready)
                predict_byte(i_byte.data_byte, i_byte.last_byte);
            // a register write takes effect from the next byte beat
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SYNC_LOW) type_low = i_cfg_data;
                else if (i_cfg_idx == CFG_SYNC_HIGH) type_high = i_cfg_data;
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/tb.sv
// Testbench top: clock, reset, packet stimulus, flow control and final verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hsfd_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 92;
    localparam int HOLD_PHASE   = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int RESET_CYCLES = 12;
    localparam int RUN_LIMIT_NS = 1_000_000;
    localparam int SHORT_LEN    = 6;

    // Indexes past the two registers; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int        fail_count;
    int        pending;
    int        idle_pct    = 0;
    int        stall_pct   = 0;
    int        phase_bytes = 0;
    logic      hold_ready  = 1'b0;
    t_nal_type cur_low     = SYNC_LOW_RST;
    t_nal_type cur_high    = SYNC_HIGH_RST;
    t_byte     pkt[$];

    hsfd_byte_if   byte_ch ();
    hsfd_result_if result_ch ();

    hevc_sync_frame_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_byte     (byte_ch),
        .o_result   (result_ch)
    );

    hsfd_sync_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_byte       (byte_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        result_ch.ready <= !hold_ready && ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the block hangs
    initial begin
        #RUN_LIMIT_NS;
        $display("hevc_sync_frame_detector: mismatch");
        $finish;
    end

    // Zeros and ones show up often so that stray start codes appear
    function automatic t_byte filler_byte();
        case ($urandom_range(7))
            0, 1:    return 8'h00;
            2:       return 8'h01;
            default: return t_byte'($urandom);
        endcase
    endfunction

    // NAL header with a type that lands in the current range now and then
    function automatic t_byte nal_header_byte();
        t_nal_type nal_type;
        if (cur_low <= cur_high && $urandom_range(99) < 30)
            nal_type = t_nal_type'($urandom_range(cur_high, cur_low));
        else
            nal_type = t_nal_type'($urandom);
        return {1'($urandom_range(1)), nal_type, 1'($urandom_range(1))};
    endfunction

    // Append one byte to the packet under construction
    task automatic add_byte(t_byte b);
        pkt.insert(pkt.size(), b);
    endtask

    // Offer one beat after a random gap and hold it until taken
    task automatic send_beat(t_byte b, logic last);
        while ($urandom_range(99) < idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt.size(); i++) send_beat(pkt[i], i == pkt.size() - 1);
        phase_bytes += pkt.size();
    endtask

    // Drop valid and wait until every verdict has come back
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both range registers, preceded by a write to an unused index
    task automatic set_range(t_nal_type low, t_nal_type high);
        cfg_we   <= 1'b1;
        cfg_idx  <= $urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B;
        cfg_data <= t_nal_type'($urandom);
        @(posedge i_clk);
        cfg_idx  <= CFG_SYNC_LOW;
        cfg_data <= low;
        @(posedge i_clk);
        cfg_idx  <= CFG_SYNC_HIGH;
        cfg_data <= high;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_low  = low;
        cur_high = high;
    endtask

    // Start code stream: 3 or 4 byte codes, header, short body
    task automatic build_annexb();
        int units, body, u, k;
        pkt.delete();
        units = $urandom_range(1, 3);
        for (u = 0; u < units; u++) begin
            if ($urandom_range(1)) add_byte(8'h00);
            add_byte(8'h00);
            add_byte(8'h00);
            add_byte(8'h01);
            // start code cut off by the packet end
            if ($urandom_range(99) < 8) break;
            add_byte(nal_header_byte());
            body = $urandom_range(0, 5);
            for (k = 0; k < body; k++) add_byte(filler_byte());
        end
    endtask

    // Length-prefixed stream with zero, huge and top-bit lengths mixed in
    task automatic build_length();
        int units, u, k, sel;
        logic [PREFIX_W-1:0] len;
        pkt.delete();
        units = $urandom_range(1, 3);
        for (u = 0; u < units; u++) begin
            sel = $urandom_range(99);
            if (sel < 6)       len = {1'b1, 31'($urandom)};
            else if (sel < 18) len = '0;
            else if (sel < 26) len = {1'b0, 31'($urandom)};
            else               len = $urandom_range(1, SHORT_LEN);
            for (k = PREFIX_BYTES - 1; k >= 0; k--) add_byte(len[BYTE_W*k +: BYTE_W]);
            // parse stops: whatever follows is ignored
            if (len[PREFIX_W-1] || (u == 0 && len == '0)) begin
                repeat ($urandom_range(0, 3)) add_byte(filler_byte());
                break;
            end
            if (len != '0) begin
                add_byte(nal_header_byte());
                // payload longer than the packet: truncate
                if (len > SHORT_LEN) begin
                    repeat ($urandom_range(0, 3)) add_byte(filler_byte());
                    break;
                end
                for (k = 1; k < len; k++) add_byte(filler_byte());
            end
        end
        // occasionally end inside a prefix or payload
        if ($urandom_range(99) < 10)
            repeat ($urandom_range(1, 3)) if (pkt.size() > 1) void'(pkt.pop_back());
    endtask

    task automatic build_noise(int max_len);
        pkt.delete();
        repeat ($urandom_range(1, max_len))
            add_byte($urandom_range(1) ? t_byte'($urandom) : filler_byte());
    endtask

    // Random packets until this phase has sent its share of bytes
    task automatic run_phase_traffic();
        int sel;
        phase_bytes = 0;
        while (phase_bytes < PHASE_BYTES) begin
            sel = $urandom_range(99);
            if (sel < 40)      build_annexb();
            else if (sel < 75) build_length();
            else if (sel < 90) build_noise(12);
            else               build_noise(PREFIX_BYTES - 1);
            send_packet();
        end
    endtask

    initial begin
        int phase;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        result_ch.ready   = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short packets, both start code lengths, a length prefix
        pkt = '{8'hFF};
        send_packet();
        pkt = '{8'h00, 8'h00, 8'h01};
        send_packet();
        pkt = '{8'h00, 8'h00, 8'h01, 8'h26};
        send_packet();
        pkt = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h40, 8'h00, 8'h00, 8'h01, 8'h2A};
        send_packet();
        pkt = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h22, 8'hFF};
        send_packet();
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: set_range(6'd0, 6'd63);
                2: set_range(6'd63, 6'd63);
                3: set_range(6'd0, 6'd0);
                4: set_range(6'd40, 6'd10);  // empty range: nothing is sync
                5: set_range(t_nal_type'($urandom), t_nal_type'($urandom));
                6: set_range(6'd19, 6'd21);
                7: set_range(SYNC_LOW_RST, SYNC_HIGH_RST);
                default: ;
            endcase
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 50; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 50; end
                default: begin idle_pct = 24; stall_pct <= 24; end
            endcase
            if (phase == HOLD_PHASE) begin
                // hold off results long enough to back up the input
                fork
                    begin
                        hold_ready <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        hold_ready <= 1'b0;
                    end
                    run_phase_traffic();
                join
            end else begin
                run_phase_traffic();
            end
            wait_drained();
        end

        if (fail_count == 0 && pending == 0)
            $display("hevc_sync_frame_detector: match");
        else
            $display("hevc_sync_frame_detector: mismatch");
        $finish;
    end

endmodule
